// ===== sv/assert_macros.svh =====
// Assertion macros shared by the ultrasonic ranging RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/urm_pkg.sv =====
// Package for the ultrasonic ranging block: word types, widths and constants.
// No dependencies.
package urm_pkg;

  localparam int SAMPLES_DEF = 5;
  localparam int TICK_W      = 16;
  localparam int CM_W        = 15;
  localparam int PROD_W      = 36;
  localparam int DIVR_W      = 22;
  localparam int QUOT_W      = 15;

  localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd62500;
  localparam logic [19:0]       MULT_C       = 20'd1000000;
  localparam logic [5:0]        DIV_C        = 6'd58;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } tick_word_t;

  typedef struct packed {
    logic            trigger_pulse;
    logic            distance_valid;
    logic [CM_W-1:0] distance_cm;
    logic            median_valid;
    logic [CM_W-1:0] median_cm;
    logic            busy_res;
  } res_word_t;

endpackage

// ===== sv/urm_cell.sv =====
// One cell of the insertion-sort chain that keeps the pulse distances in order.
// Depends on urm_pkg.
module urm_cell (
  input  logic                    clk,
  input  logic                    ins_en,
  input  logic [urm_pkg::CM_W-1:0] din,
  input  logic [urm_pkg::CM_W-1:0] left_val,
  input  logic                    left_gt,
  input  logic                    filled,
  input  logic                    slot,
  output logic [urm_pkg::CM_W-1:0] val,
  output logic                    gt
);
  import urm_pkg::*;

  assign gt = filled && (val > din);

  always_ff @(posedge clk) begin
    if (ins_en && (gt || slot)) begin
      val <= left_gt ? left_val : din;
    end
  end

endmodule

// ===== sv/urm_divider.sv =====
// Converts a pulse tick count to centimetres: ticks * 1000000 / (period * 58).
// A registered multiply, then a restoring divider that makes one quotient bit a cycle.
// Depends on urm_pkg.
module urm_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [urm_pkg::TICK_W-1:0] ticks,
  input  logic [urm_pkg::DIVR_W-1:0] divisor,
  output logic                      done,
  output logic [urm_pkg::QUOT_W-1:0] quot
);
  import urm_pkg::*;

  localparam int QCNT_W = $clog2(QUOT_W);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]        state;
  logic [QCNT_W-1:0] cnt;
  logic [PROD_W-1:0] prod;
  logic [DIVR_W-1:0] rem;
  logic [QUOT_W-1:0] low;
  logic [DIVR_W:0]   trial;
  logic              take;

  assign trial = {rem, low[QUOT_W-1]};
  assign take  = trial >= {1'b0, divisor};
  assign quot  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          cnt <= cnt + QCNT_W'(1);
          if (cnt == QCNT_W'(QUOT_W - 1)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      prod <= PROD_W'(ticks) * PROD_W'(MULT_C);
    end
    if (state == S_LOAD) begin
      rem <= DIVR_W'(prod[PROD_W-1:QUOT_W]);
      low <= prod[QUOT_W-1:0];
    end else if (state == S_DIV) begin
      rem <= take ? DIVR_W'(trial - {1'b0, divisor}) : DIVR_W'(trial);
      low <= {low[QUOT_W-2:0], take};
    end
  end

endmodule

// ===== sv/ultrasonic_range_median_top.sv =====
// Top level of the ultrasonic echo ranging block with a median filter.
// Depends on urm_pkg, urm_cell, urm_divider and assert_macros.svh.
//
// Usage:
//   Each word on the tick channel (tick_valid, tick_stall, tick_word) is one timer tick
//   with the start request and the sampled echo level. Each accepted tick gives exactly
//   one word on the result channel (res_valid, res_stall, res_word).
//   A tick that does not end a pulse gives its result in the cycle after acceptance, and a
//   new tick is taken every cycle while the result side keeps up.
//   A tick that ends a pulse starts the conversion: the accepting edge does the multiply,
//   then come a load step, one divider step per quotient bit, a step to capture the
//   quotient, one to insert the distance into the sorted cell chain and one to read the
//   median. tick_stall stays high until its result word is taken.
//   While res_valid and res_stall are both high the result word holds and no further tick is taken.
//   cfg_write_en writes the period from cfg_write_data (zero is taken as 1); write it only when idle.
//   Reset (rst, synchronous) returns to idle, clears the series and sets the period
//   to 62500. The distance cells need no clearing.
`include "assert_macros.svh"

module ultrasonic_range_median_top #(
  parameter int SAMPLES_PER_CAPTURE = urm_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick_valid,
  output logic                       tick_stall,
  input  urm_pkg::tick_word_t        tick_word,
  output logic                       res_valid,
  input  logic                       res_stall,
  output urm_pkg::res_word_t         res_word,
  input  logic                       cfg_write_en,
  input  logic [urm_pkg::TICK_W-1:0] cfg_write_data
);
  import urm_pkg::*;

  localparam int FILL_W = $clog2(SAMPLES_PER_CAPTURE + 1);
  localparam int MID    = SAMPLES_PER_CAPTURE / 2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [1:0] CALC_IDLE = 2'd0;
  localparam logic [1:0] CALC_DIV  = 2'd1;
  localparam logic [1:0] CALC_INS  = 2'd2;
  localparam logic [1:0] CALC_OUT  = 2'd3;

  logic [TICK_W-1:0] period;
  logic [DIVR_W-1:0] divisor;
  logic [TICK_W-1:0] cfg_eff;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [TICK_W-1:0] pulse_ticks;
  logic [TICK_W-1:0] pulse_ticks_next;
  logic [TICK_W-1:0] ticks_end;
  logic [TICK_W-1:0] ticks_inc;
  logic [FILL_W-1:0] fill_count;
  logic              finish;
  logic              trig;
  logic              mval;
  logic              fill_clr;
  logic              last_pulse;

  logic [1:0]        calc;
  logic              pend_trig;
  logic              pend_mval;
  logic              pend_busy;
  logic [CM_W-1:0]   pulse_cm;

  logic              accept;
  logic              slot_free;
  logic              out_from_calc;

  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  logic [CM_W-1:0]   cell_val [SAMPLES_PER_CAPTURE];
  logic              cell_gt  [SAMPLES_PER_CAPTURE];
  logic              ins_en;

  assign slot_free     = !res_valid || !res_stall;
  assign tick_stall    = (calc != CALC_IDLE) || !slot_free;
  assign accept        = tick_valid && !tick_stall;
  assign out_from_calc = (calc == CALC_OUT) && slot_free;
  assign ins_en        = (calc == CALC_INS);
  assign cfg_eff       = (cfg_write_data == '0) ? TICK_W'(1) : cfg_write_data;
  assign last_pulse    = ({1'b0, fill_count} + (FILL_W+1)'(1))
                         == (FILL_W+1)'(SAMPLES_PER_CAPTURE);
  assign ticks_inc     = (pulse_ticks < period) ? pulse_ticks + TICK_W'(1) : pulse_ticks;

  always_comb begin
    phase_next       = phase;
    pulse_ticks_next = pulse_ticks;
    ticks_end        = pulse_ticks;
    finish           = 1'b0;
    trig             = 1'b0;
    mval             = 1'b0;
    fill_clr         = 1'b0;
    unique case (phase)
      PH_WAIT: begin
        if (tick_word.echo_level) begin
          pulse_ticks_next = TICK_W'(1);
          if (period <= TICK_W'(1)) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_HIGH;
          end
        end else begin
          pulse_ticks_next = '0;
        end
      end
      PH_HIGH: begin
        if (tick_word.echo_level) begin
          pulse_ticks_next = ticks_inc;
          if (ticks_inc >= period) begin
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (tick_word.start_req) begin
          trig             = 1'b1;
          fill_clr         = 1'b1;
          pulse_ticks_next = '0;
          phase_next       = PH_WAIT;
        end
      end
    endcase
    if (finish) begin
      ticks_end        = pulse_ticks_next;
      pulse_ticks_next = '0;
      if (last_pulse) begin
        mval       = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        trig       = 1'b1;
        phase_next = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= PERIOD_RESET;
      divisor <= DIVR_W'(PERIOD_RESET) * DIVR_W'(DIV_C);
    end else if (cfg_write_en) begin
      period  <= cfg_eff;
      divisor <= DIVR_W'(cfg_eff) * DIVR_W'(DIV_C);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pulse_ticks <= '0;
      fill_count  <= '0;
      calc        <= CALC_IDLE;
      res_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        pulse_ticks <= pulse_ticks_next;
        if (fill_clr) begin
          fill_count <= '0;
        end
        if (finish) begin
          calc <= CALC_DIV;
        end
      end
      unique case (calc)
        CALC_DIV: begin
          if (div_done) begin
            calc <= CALC_INS;
          end
        end
        CALC_INS: begin
          fill_count <= fill_count + FILL_W'(1);
          calc       <= CALC_OUT;
        end
        CALC_OUT: begin
          if (slot_free) begin
            calc <= CALC_IDLE;
          end
        end
        default: begin
        end
      endcase
      if ((accept && !finish) || out_from_calc) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && finish) begin
      pend_trig <= trig;
      pend_mval <= mval;
      pend_busy <= (phase_next != PH_IDLE);
    end
    if (calc == CALC_DIV && div_done) begin
      pulse_cm <= div_quot;
    end
    if (accept && !finish) begin
      res_word.trigger_pulse  <= trig;
      res_word.distance_valid <= 1'b0;
      res_word.distance_cm    <= '0;
      res_word.median_valid   <= 1'b0;
      res_word.median_cm      <= '0;
      res_word.busy_res       <= (phase_next != PH_IDLE);
    end else if (out_from_calc) begin
      res_word.trigger_pulse  <= pend_trig;
      res_word.distance_valid <= 1'b1;
      res_word.distance_cm    <= pulse_cm;
      res_word.median_valid   <= pend_mval;
      res_word.median_cm      <= pend_mval ? cell_val[MID] : '0;
      res_word.busy_res       <= pend_busy;
    end
  end

  urm_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && finish),
    .ticks   (ticks_end),
    .divisor (divisor),
    .done    (div_done),
    .quot    (div_quot)
  );

  for (genvar i = 0; i < SAMPLES_PER_CAPTURE; i++) begin : g_cell
    logic [CM_W-1:0] left_val;
    logic            left_gt;
    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    urm_cell u_cell (
      .clk      (clk),
      .ins_en   (ins_en),
      .din      (pulse_cm),
      .left_val (left_val),
      .left_gt  (left_gt),
      .filled   (FILL_W'(i) < fill_count),
      .slot     (FILL_W'(i) == fill_count),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  `ASSERT_SAME(a_done_in_div, div_done, calc == CALC_DIV, "divider done outside wait")
  `ASSERT_SAME(a_fill_bound, 1'b1, fill_count <= FILL_W'(SAMPLES_PER_CAPTURE),
               "fill count beyond series length")
  `ASSERT_SAME(a_median_full, out_from_calc && pend_mval,
               fill_count == FILL_W'(SAMPLES_PER_CAPTURE), "median before series full")
  `ASSERT_SAME(a_high_below, phase == PH_HIGH, pulse_ticks < period,
               "pulse count reached period while high")
  `ASSERT_NEXT(a_ins_to_out, calc == CALC_INS, calc == CALC_OUT, "insert not followed by output")

endmodule

// ===== bench/urm_checker.sv =====
// Checker for the ultrasonic ranging block: watches the tick, result and period ports.
// It predicts every result word from its own copy of the ranging state and compares them.
// Depends on urm_pkg.
module urm_checker #(
  parameter int PULSES = urm_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick_valid,
  input  logic                       tick_stall,
  input  urm_pkg::tick_word_t        tick_word,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  urm_pkg::res_word_t         res_word,
  input  logic                       cfg_write_en,
  input  logic [urm_pkg::TICK_W-1:0] cfg_write_data,
  output int                         fail_count,
  output int                         pending,
  output logic                       series_busy,
  output int                         medians_seen
);
  import urm_pkg::*;

  localparam logic [1:0] RP_IDLE       = 2'd0;
  localparam logic [1:0] RP_AWAIT_ECHO = 2'd1;
  localparam logic [1:0] RP_ECHO_HIGH  = 2'd2;

  logic [TICK_W-1:0] period_reg;
  logic [1:0]        phase_q;
  logic [TICK_W-1:0] echo_ticks;
  logic [CM_W-1:0]   sorted_cm [PULSES];
  int                fill;
  int                errors;
  int                medians;
  res_word_t         expected_words [$];

  function automatic logic [CM_W-1:0] ticks_to_cm(input logic [TICK_W-1:0] ticks,
                                                  input logic [TICK_W-1:0] per);
    longint unsigned prod;
    prod = longint'(ticks) * 64'd1000000;
    prod = prod / longint'(per);
    prod = prod / 64'd58;
    return prod[CM_W-1:0];
  endfunction

  function automatic res_word_t predict_result(input tick_word_t w);
    res_word_t         r;
    logic              done;
    logic [TICK_W-1:0] per;
    int                i;
    r    = '0;
    done = 1'b0;
    per  = (period_reg == '0) ? TICK_W'(1) : period_reg;
    case (phase_q)
      RP_AWAIT_ECHO: begin
        if (w.echo_level) begin
          echo_ticks = TICK_W'(1);
          if (echo_ticks >= per) done = 1'b1;
          else phase_q = RP_ECHO_HIGH;
        end else begin
          echo_ticks = '0;
        end
      end
      RP_ECHO_HIGH: begin
        if (w.echo_level) begin
          if (echo_ticks < per) echo_ticks = echo_ticks + TICK_W'(1);
          if (echo_ticks >= per) done = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        phase_q = RP_IDLE;
        if (w.start_req) begin
          r.trigger_pulse = 1'b1;
          fill            = 0;
          echo_ticks      = '0;
          phase_q         = RP_AWAIT_ECHO;
        end
      end
    endcase
    if (done) begin
      r.distance_valid = 1'b1;
      r.distance_cm    = ticks_to_cm(echo_ticks, per);
      if (fill < PULSES) begin
        i = fill;
        while (i > 0 && sorted_cm[i-1] > r.distance_cm) begin
          sorted_cm[i] = sorted_cm[i-1];
          i--;
        end
        sorted_cm[i] = r.distance_cm;
        fill++;
      end
      echo_ticks = '0;
      if (fill >= PULSES) begin
        r.median_valid = 1'b1;
        r.median_cm    = sorted_cm[PULSES/2];
        phase_q        = RP_IDLE;
      end else begin
        r.trigger_pulse = 1'b1;
        phase_q         = RP_AWAIT_ECHO;
      end
    end
    r.busy_res = (phase_q != RP_IDLE);
    return r;
  endfunction

  task automatic check_field(input string label, input logic [CM_W-1:0] want,
                             input logic [CM_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_word_t want;
    if (rst) begin
      period_reg = PERIOD_RESET;
      phase_q    = RP_IDLE;
      echo_ticks = '0;
      fill       = 0;
      expected_words.delete();
    end else begin
      if (cfg_write_en) period_reg = cfg_write_data;
      if (res_valid && !res_stall) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, expected none, got %p",
                   $time, res_word);
        end else begin
          want = expected_words.pop_front();
          check_field("trigger_pulse", CM_W'(want.trigger_pulse),
                      CM_W'(res_word.trigger_pulse));
          check_field("distance_valid", CM_W'(want.distance_valid),
                      CM_W'(res_word.distance_valid));
          check_field("distance_cm", want.distance_cm, res_word.distance_cm);
          check_field("median_valid", CM_W'(want.median_valid),
                      CM_W'(res_word.median_valid));
          check_field("median_cm", want.median_cm, res_word.median_cm);
          check_field("busy_res", CM_W'(want.busy_res), CM_W'(res_word.busy_res));
          if (want.median_valid) medians++;
        end
      end
      if (tick_valid && !tick_stall) expected_words.push_back(predict_result(tick_word));
    end
    fail_count   <= errors;
    pending      <= expected_words.size();
    series_busy  <= (phase_q != RP_IDLE);
    medians_seen <= medians;
  end

endmodule

// ===== bench/tb_ultrasonic_range_median_top.sv =====
// Testbench top for the ultrasonic ranging block with a median filter.
// Drives tick words, result stalls and period writes; urm_checker predicts and compares.
// Depends on urm_pkg, urm_checker and the block's RTL.
module tb_ultrasonic_range_median_top;
  import urm_pkg::*;

  localparam int PULSES = SAMPLES_DEF;

  logic              clk;
  logic              rst            = 1'b1;
  logic              tick_valid     = 1'b0;
  tick_word_t        tick_word      = '0;
  logic              res_stall      = 1'b0;
  logic              cfg_write_en   = 1'b0;
  logic [TICK_W-1:0] cfg_write_data = '0;
  logic              tick_stall;
  logic              res_valid;
  res_word_t         res_word;

  int   fail_count;
  int   pending;
  logic series_busy;
  int   medians_seen;
  int   sent;
  int   settings;
  bit   steady;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  ultrasonic_range_median_top DUT (
    .clk           (clk),
    .rst           (rst),
    .tick_valid    (tick_valid),
    .tick_stall    (tick_stall),
    .tick_word     (tick_word),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_word      (res_word),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  urm_checker #(.PULSES(PULSES)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .tick_valid    (tick_valid),
    .tick_stall    (tick_stall),
    .tick_word     (tick_word),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_word      (res_word),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .series_busy   (series_busy),
    .medians_seen  (medians_seen)
  );

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= !steady && ($urandom_range(99) < 34);
    end
  end

  task automatic send_tick(input bit start, input bit echo);
    tick_word_t w;
    w.start_req  = start;
    w.echo_level = echo;
    tick_valid  <= 1'b1;
    tick_word   <= w;
    do @(posedge clk); while (tick_stall);
    sent++;
    if (!steady && $urandom_range(99) < 30) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  task automatic pulse(input int lo_ticks, input int hi_ticks);
    repeat (lo_ticks) send_tick($urandom_range(7) == 0, 1'b0);
    repeat (hi_ticks) send_tick($urandom_range(7) == 0, 1'b1);
    send_tick($urandom_range(7) == 0, 1'b0);
  endtask

  task automatic settle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic finish_series();
    settle();
    while (series_busy) begin
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      settle();
    end
  endtask

  task automatic write_period(input logic [TICK_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [TICK_W-1:0] fixed_periods [6];
    logic [TICK_W-1:0] per;
    int                max_hi;
    int                phase_idx;
    fixed_periods = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'hAAAA, 16'h5555};
    phase_idx     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    pulse(0, 1);
    pulse(1, 4);
    pulse(0, 2);
    pulse(0, 3);
    pulse(0, 6);
    settings = 1;

    while (sent < 1100) begin
      finish_series();
      if (phase_idx < 6) begin
        per = fixed_periods[phase_idx];
      end else if ($urandom_range(3) == 0) begin
        per = TICK_W'($urandom_range(65535, 1));
      end else begin
        per = TICK_W'($urandom_range(40, 1));
      end
      write_period(per);
      steady = (phase_idx == 3);
      max_hi = (per == '0) ? 3 : ((per <= 40) ? int'(per) + 2 : 40);
      repeat (steady ? 6 : $urandom_range(4, 2)) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(4, 1)) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
          end
        end
        if ($urandom_range(7) == 0) settle();
        send_tick(1'b1, 1'($urandom_range(1)));
        repeat (PULSES) pulse($urandom_range(3), $urandom_range(max_hi, 1));
      end
      steady = 1'b0;
      phase_idx++;
    end

    settle();
    repeat (40) @(posedge clk);
    $display("Sent %0d tick words over %0d period settings; %0d series medians checked.",
             sent, settings, medians_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Timed out with %0d result words outstanding.", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule
